/* design/amtsg_pkg.sv */
// ============================================================================
// amtsg_pkg
// Shared types, constants and the sine table function of the AM test
// signal generator.
// ============================================================================
package amtsg_pkg;

    // Default structural sizes
    localparam int PHASE_BITS_DEF      = 32;
    localparam int SINE_TABLE_BITS_DEF = 10;
    localparam int MAX_FRAME_LOG2_DEF  = 16;

    // Fixed field widths
    localparam int CFG_DATA_W   = 32;
    localparam int CFG_INDEX_W  = 3;
    localparam int STEP_W       = 32;
    localparam int GAIN_W       = 16;
    localparam int FLOG2_W      = 5;
    localparam int LFSR_W       = 32;
    localparam int SAMPLE_W     = 24;
    localparam int FIDX_W       = 16;
    localparam int ROM_W        = 16;
    localparam int S_TDATA_W    = 8;
    localparam int M_TDATA_W    = 40;

    // Register reset values
    localparam logic [STEP_W-1:0]  CARRIER_STEP_RST = 32'd429496730;
    localparam logic [STEP_W-1:0]  MOD_STEP_RST     = 32'd42949673;
    localparam logic [GAIN_W-1:0]  NOISE_GAIN_RST   = 16'd1229;
    localparam logic [FLOG2_W-1:0] FLOG2_RST        = 5'd11;
    localparam logic [LFSR_W-1:0]  NOISE_SEED_RST   = 32'd1;

    localparam logic [LFSR_W-1:0]  LFSR_TAPS   = 32'hB4BC3525;
    localparam logic [63:0]        HALF_PI_Q30 = 64'd1686629713;

    // Taylor series divisors (2n)(2n+1) for n = 1..10
    localparam logic [63:0] TAYLOR_DIV [10] = '{
        64'd6, 64'd20, 64'd42, 64'd72, 64'd110,
        64'd156, 64'd210, 64'd272, 64'd342, 64'd420
    };

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_CARRIER_STEP = 3'd0,
        CFG_MOD_STEP     = 3'd1,
        CFG_NOISE_GAIN   = 3'd2,
        CFG_FRAME_LOG2   = 3'd3,
        CFG_CONTINUOUS   = 3'd4,
        CFG_NOISE_SEED   = 3'd5
    } t_cfg_reg;

    // One sine table entry, Q1.15. Quarter wave from a truncating Taylor
    // series in Q30, mirrored and negated for the other quarters.
    function automatic logic signed [ROM_W-1:0] sine_entry(input int idx, input int tbits);
        logic [63:0] quarter;
        logic [63:0] q;
        logic [63:0] r;
        logic [63:0] k;
        logic [63:0] x;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] v;
        int          n;
        quarter = 64'd1 << (tbits - 2);
        q       = 64'(idx) >> (tbits - 2);
        r       = 64'(idx) & (quarter - 64'd1);
        k       = q[0] ? (quarter - r) : r;
        x       = (k * HALF_PI_Q30) >> (tbits - 2);
        term    = x;
        sum     = x;
        for (n = 1; n <= 10; n++) begin
            term = (term * x) >> 30;
            term = (term * x) >> 30;
            term = term / TAYLOR_DIV[n-1];
            if (n % 2 == 1) begin
                sum = (sum >= term) ? (sum - term) : 64'd0;
            end else begin
                sum = sum + term;
            end
        end
        v = (sum + 64'd16384) >> 15;
        if (v > 64'd32767) begin
            v = 64'd32767;
        end
        return q[1] ? -(v[ROM_W-1:0]) : v[ROM_W-1:0];
    endfunction

endpackage

/* design/am_test_signal_generator_top.sv */
// ============================================================================
// am_test_signal_generator_top
// AM test signal source: carrier sine times (modulator sine + 1) plus
// scaled uniform LFSR noise, grouped in frames.
// ============================================================================
//
//  Channel   | Dir | Beat contents (lowest bit first)
//  ----------+-----+-----------------------------------------------------
//  s_axis    | in  | tdata[0] restart, tdata[7:1] zero
//  m_axis    | out | tdata[23:0] sample (Q8.16), tdata[39:24] frame_index,
//            |     | tlast last_in_frame
//  cfg       | in  | i_cfg_wr_en, i_cfg_index, i_cfg_data (write only)
//
//  One input beat per clock is taken while s_axis_tready is high; each one
//  not swallowed by a stopped generator gives one output beat through the
//  sine table read register, multiplier register and output register.
//  Synchronous active-low reset returns registers to their defaults and
//  leaves the generator running at the start of a frame.
//  Stalls on m_axis back up stage by stage; s_axis keeps flowing into any
//  empty stage, so bubbles are squeezed out before the input is held.
// ============================================================================
module am_test_signal_generator_top
    import amtsg_pkg::*;
#(
    parameter int PHASE_BITS      = PHASE_BITS_DEF,
    parameter int SINE_TABLE_BITS = SINE_TABLE_BITS_DEF,
    parameter int MAX_FRAME_LOG2  = MAX_FRAME_LOG2_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,

    input  logic                   i_cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,

    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [S_TDATA_W-1:0]   s_axis_tdata,   // [0] restart

    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [M_TDATA_W-1:0]   m_axis_tdata,   // [23:0] sample, [39:24] frame_index
    output logic                   m_axis_tlast    // last_in_frame
);

    localparam int PB        = PHASE_BITS;
    localparam int TB        = SINE_TABLE_BITS;
    localparam int CW        = MAX_FRAME_LOG2;
    localparam int ROM_DEPTH = 1 << TB;
    localparam int PROD_W    = 32;
    localparam int TOTAL_W   = PROD_W + 4;

    typedef logic signed [ROM_W-1:0] t_rom [ROM_DEPTH];

    function automatic t_rom build_rom();
        t_rom rom;
        for (int i = 0; i < ROM_DEPTH; i++) begin
            rom[i] = sine_entry(i, TB);
        end
        return rom;
    endfunction

    localparam t_rom SINE_ROM = build_rom();

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [STEP_W-1:0]  r_carrier_step;
    logic [STEP_W-1:0]  r_mod_step;
    logic [GAIN_W-1:0]  r_noise_gain;
    logic [FLOG2_W-1:0] r_frame_log2;
    logic               r_continuous;
    logic [LFSR_W-1:0]  r_noise_seed;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_carrier_step <= CARRIER_STEP_RST;
            r_mod_step     <= MOD_STEP_RST;
            r_noise_gain   <= NOISE_GAIN_RST;
            r_frame_log2   <= FLOG2_RST;
            r_continuous   <= 1'b0;
            r_noise_seed   <= NOISE_SEED_RST;
        end else if (i_cfg_wr_en) begin
            case (t_cfg_reg'(i_cfg_index))
                CFG_CARRIER_STEP: r_carrier_step <= i_cfg_data[STEP_W-1:0];
                CFG_MOD_STEP:     r_mod_step     <= i_cfg_data[STEP_W-1:0];
                CFG_NOISE_GAIN:   r_noise_gain   <= i_cfg_data[GAIN_W-1:0];
                CFG_FRAME_LOG2:   r_frame_log2   <= i_cfg_data[FLOG2_W-1:0];
                CFG_CONTINUOUS:   r_continuous   <= i_cfg_data[0];
                CFG_NOISE_SEED:   r_noise_seed   <= i_cfg_data[LFSR_W-1:0];
                default: begin
                    // unknown index: drop the write
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Generator state and its update at each accepted beat
    // ------------------------------------------------------------------
    logic [PB-1:0]     r_carrier_phase, n_carrier_phase;
    logic [PB-1:0]     r_mod_phase,     n_mod_phase;
    logic [CW-1:0]     r_count,         n_count;
    logic [LFSR_W-1:0] r_lfsr,          n_lfsr;
    logic              r_stopped,       n_stopped;

    logic              accept;
    logic              restart;
    logic              produce;
    logic [PB-1:0]     cp0, mp0;
    logic [CW-1:0]     cnt0;
    logic [LFSR_W-1:0] lfsr0, lfsr1, seed_ld;
    logic              stop0;
    logic [FLOG2_W-1:0] lg;
    logic [CW-1:0]     len_m1;
    logic              last;
    logic [PB+STEP_W-1:0] c_step_ext, m_step_ext;
    logic [TB-1:0]     c_addr, m_addr;

    assign accept  = s_axis_tvalid && s_axis_tready;
    assign restart = s_axis_tdata[0];

    // A zero seed would lock the LFSR: load one instead
    assign seed_ld = (r_noise_seed == '0) ? LFSR_W'(1) : r_noise_seed;

    assign cp0   = restart ? '0 : r_carrier_phase;
    assign mp0   = restart ? '0 : r_mod_phase;
    assign cnt0  = restart ? '0 : r_count;
    assign lfsr0 = restart ? seed_ld : r_lfsr;
    assign stop0 = restart ? 1'b0 : r_stopped;

    assign produce = accept && !stop0;

    assign lfsr1 = lfsr0[0] ? ((lfsr0 >> 1) ^ LFSR_TAPS) : (lfsr0 >> 1);

    // Clamp the frame length, then form length minus one as a mask
    assign lg     = (r_frame_log2 > FLOG2_W'(CW)) ? FLOG2_W'(CW) : r_frame_log2;
    assign len_m1 = ~({CW{1'b1}} << lg);
    // Counter at or past the end (frame shrunk mid-way) closes the frame
    assign last   = (cnt0 >= len_m1);

    assign c_step_ext = {{PB{1'b0}}, r_carrier_step};
    assign m_step_ext = {{PB{1'b0}}, r_mod_step};

    assign c_addr = cp0[PB-1 -: TB];
    assign m_addr = mp0[PB-1 -: TB];

    always_comb begin
        n_carrier_phase = cp0;
        n_mod_phase     = mp0;
        n_count         = cnt0;
        n_lfsr          = lfsr0;
        n_stopped       = stop0;
        if (!stop0) begin
            n_lfsr = lfsr1;
            if (last) begin
                n_carrier_phase = '0;
                n_mod_phase     = '0;
                n_count         = '0;
                n_stopped       = !r_continuous;
            end else begin
                n_carrier_phase = cp0 + c_step_ext[PB-1:0];
                n_mod_phase     = mp0 + m_step_ext[PB-1:0];
                n_count         = cnt0 + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_carrier_phase <= '0;
            r_mod_phase     <= '0;
            r_count         <= '0;
            r_lfsr          <= NOISE_SEED_RST;
            r_stopped       <= 1'b0;
        end else if (accept) begin
            r_carrier_phase <= n_carrier_phase;
            r_mod_phase     <= n_mod_phase;
            r_count         <= n_count;
            r_lfsr          <= n_lfsr;
            r_stopped       <= n_stopped;
        end
    end

    // ------------------------------------------------------------------
    // Pipeline: table read, multiply, sum/round/output
    // ------------------------------------------------------------------
    logic adv1, adv2, adv3;

    logic                     r1_valid;
    logic signed [ROM_W-1:0]  r1_carrier;
    logic signed [ROM_W-1:0]  r1_mod;
    logic [GAIN_W-1:0]        r1_noise;
    logic [FIDX_W-1:0]        r1_index;
    logic                     r1_last;

    logic                     r2_valid;
    logic signed [PROD_W-1:0] r2_prod;
    logic signed [PROD_W-1:0] r2_noise;
    logic [FIDX_W-1:0]        r2_index;
    logic                     r2_last;

    logic                     r_out_valid;
    logic signed [SAMPLE_W-1:0] r_out_sample;
    logic [FIDX_W-1:0]        r_out_index;
    logic                     r_out_last;

    logic [CW+FIDX_W-1:0]     cnt_ext;

    assign adv3 = !r_out_valid || m_axis_tready;
    assign adv2 = !r2_valid || adv3;
    assign adv1 = !r1_valid || adv2;
    assign s_axis_tready = adv1;

    assign cnt_ext = {{FIDX_W{1'b0}}, cnt0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (adv1) begin
            r1_valid <= produce;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv1) begin
            r1_carrier <= SINE_ROM[c_addr];
            r1_mod     <= SINE_ROM[m_addr];
            r1_noise   <= lfsr1[LFSR_W-1 -: GAIN_W];
            r1_index   <= cnt_ext[FIDX_W-1:0];
            r1_last    <= last;
        end
    end

    // m + 1/2 full scale and noise - 1/2 are both a flip of the top bit
    logic signed [ROM_W:0]      mod_off;
    logic signed [GAIN_W-1:0]   noise_off;
    logic signed [GAIN_W:0]     gain_s;
    logic signed [PROD_W:0]     prod_full;
    logic signed [PROD_W:0]     noise_full;

    assign mod_off    = {1'b0, ~r1_mod[ROM_W-1], r1_mod[ROM_W-2:0]};
    assign noise_off  = {~r1_noise[GAIN_W-1], r1_noise[GAIN_W-2:0]};
    assign gain_s     = {1'b0, r_noise_gain};
    assign prod_full  = r1_carrier * mod_off;
    assign noise_full = noise_off * gain_s;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (adv2) begin
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv2) begin
            r2_prod  <= prod_full[PROD_W-1:0];
            r2_noise <= noise_full[PROD_W-1:0];
            r2_index <= r1_index;
            r2_last  <= r1_last;
        end
    end

    // Sum in Q.30, round half up and floor to Q8.16. The sum stays within
    // about 2^33.3, so the result fits 22 bits and never reaches the
    // clipping limits: sign-extend.
    logic signed [TOTAL_W-1:0] total;
    logic signed [TOTAL_W-1:0] rounded;

    assign total   = TOTAL_W'(r2_prod) + (TOTAL_W'(r2_noise) <<< 2);
    assign rounded = (total + TOTAL_W'(8192)) >>> 14;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv3) begin
            r_out_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv3) begin
            r_out_sample <= rounded[SAMPLE_W-1:0];
            r_out_index  <= r2_index;
            r_out_last   <= r2_last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_index, r_out_sample};
    assign m_axis_tlast  = r_out_last;

endmodule

/* tb/am_test_signal_generator_top_tb.sv */
// ============================================================================
// am_test_signal_generator_top_tb
// Self-checking bench for the AM test signal generator: every output beat
// is compared against a cycle-free model of the phase accumulators, sine
// table, noise LFSR and frame sequencing. Directed register and frame
// corner cases and a long output hold-off that backs the pipeline up into
// the input come first, then randomised bursts under four idle profiles.
// ============================================================================
module am_test_signal_generator_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import amtsg_pkg::*;

    localparam int CLK_HALF    = 6;
    localparam int PIPE_SETTLE = 8;          // three stages plus margin
    localparam int TIMEOUT_NS  = 3_000_000;
    localparam int LUT_DEPTH   = 1024;
    localparam int LUT_QUARTER = LUT_DEPTH / 4;
    localparam int FRAME_LOG2_CAP = 16;
    localparam int HOLD_OFF_CYCLES = 300;

    localparam logic [31:0] NOISE_TAPS      = 32'hB4BC3525;
    localparam longint unsigned RIGHT_ANGLE_Q30 = 64'd1686629713;

    // Indexes past the register map; the block must ignore writes to them
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_HI = 3'd7;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic [FIDX_W-1:0]          frame_index;
        logic                       last;
    } sample_beat_t;

    // ------------------------------------------------------------------
    // DUT connections; every input starts at a known value
    // ------------------------------------------------------------------
    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   i_cfg_wr_en   = 1'b0;
    logic [CFG_INDEX_W-1:0] i_cfg_index   = CFG_CARRIER_STEP;
    logic [CFG_DATA_W-1:0]  i_cfg_data    = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [S_TDATA_W-1:0]   s_axis_tdata  = '0;   // [0] restart
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_axis_tdata;         // [23:0] sample, [39:24] frame_index
    logic                   m_axis_tlast;         // last_in_frame

    am_test_signal_generator_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // ------------------------------------------------------------------
    // Generator model: registers, running state and the sine table
    // ------------------------------------------------------------------
    logic [31:0]        reg_carrier_step;
    logic [31:0]        reg_mod_step;
    logic [15:0]        reg_noise_gain;
    logic [4:0]         reg_frame_log2;
    logic               reg_continuous;
    logic [31:0]        reg_noise_seed;

    logic [31:0]        carrier_acc;
    logic [31:0]        mod_acc;
    int unsigned        frame_pos;
    logic [31:0]        noise_reg;
    bit                 halted;
    logic signed [15:0] sine_lut [LUT_DEPTH];

    sample_beat_t       pending_samples [$];

    // Run bookkeeping
    int  mismatch_count    = 0;
    int  results_predicted = 0;
    int  results_checked   = 0;
    int  frames_closed     = 0;
    int  reg_writes        = 0;
    int  input_stalls      = 0;
    int  send_idle_pct     = 0;
    int  rx_stall_pct      = 0;
    logic rx_hold          = 1'b0;

    // ------------------------------------------------------------------
    // Clock and watchdog
    // ------------------------------------------------------------------
    initial begin
        forever #(CLK_HALF) i_clk = ~i_clk;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("[FAIL] regression broken");
        $finish;
    end

    // Quarter-wave Taylor series in Q30, rounded to Q15 and folded out to
    // a full period.
    function automatic logic signed [15:0] sine_q15(input int unsigned idx);
        longint unsigned r;
        longint unsigned k;
        longint unsigned x;
        longint unsigned term;
        longint unsigned acc;
        longint unsigned v;
        int unsigned     seg;
        int unsigned     n;
        seg = idx / LUT_QUARTER;
        r   = idx % LUT_QUARTER;
        k   = seg[0] ? (LUT_QUARTER - r) : r;
        x   = k * RIGHT_ANGLE_Q30 / LUT_QUARTER;
        term = x;
        acc  = x;
        for (n = 1; n <= 10; n++) begin
            term = (term * x) >> 30;
            term = (term * x) >> 30;
            term = term / ((2 * n) * (2 * n + 1));
            if (n % 2 == 1) begin
                acc = (acc >= term) ? (acc - term) : 0;
            end else begin
                acc = acc + term;
            end
        end
        v = (acc + 16384) >> 15;
        if (v > 32767) begin
            v = 32767;
        end
        return seg[1] ? -$signed(v[15:0]) : $signed(v[15:0]);
    endfunction

    task automatic reset_model();
        reg_carrier_step = 32'd429496730;
        reg_mod_step     = 32'd42949673;
        reg_noise_gain   = 16'd1229;
        reg_frame_log2   = 5'd11;
        reg_continuous   = 1'b0;
        reg_noise_seed   = 32'd1;
        carrier_acc      = '0;
        mod_acc          = '0;
        frame_pos        = 0;
        noise_reg        = 32'd1;
        halted           = 1'b0;
    endtask

    task automatic apply_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0]  value);
        case (idx)
            CFG_CARRIER_STEP: reg_carrier_step = value;
            CFG_MOD_STEP:     reg_mod_step     = value;
            CFG_NOISE_GAIN:   reg_noise_gain   = value[15:0];
            CFG_FRAME_LOG2:   reg_frame_log2   = value[4:0];
            CFG_CONTINUOUS:   reg_continuous   = value[0];
            CFG_NOISE_SEED:   reg_noise_seed   = value;
            default: ;
        endcase
    endtask

    // Advance the model by one accepted beat and queue the sample it gives
    task automatic next_sample(input bit restart);
        int unsigned     lg;
        longint unsigned frame_len;
        longint          c;
        longint          m;
        longint          nz;
        longint          gain;
        longint          total;
        longint          res;
        sample_beat_t    beat;
        if (restart) begin
            frame_pos   = 0;
            carrier_acc = '0;
            mod_acc     = '0;
            halted      = 1'b0;
            noise_reg   = (reg_noise_seed != 0) ? reg_noise_seed : 32'd1;
        end
        if (halted) begin
            return;
        end
        lg        = (reg_frame_log2 > FRAME_LOG2_CAP) ? FRAME_LOG2_CAP : reg_frame_log2;
        frame_len = 64'd1 << lg;
        noise_reg = noise_reg[0] ? ((noise_reg >> 1) ^ NOISE_TAPS) : (noise_reg >> 1);

        c     = sine_lut[carrier_acc[31:22]];
        m     = sine_lut[mod_acc[31:22]];
        nz    = noise_reg[31:16];
        gain  = reg_noise_gain;
        total = c * (m + 32768) + (nz - 32768) * gain * 4;
        res   = (total + 8192) >>> 14;
        if (res > 8388607) begin
            res = 8388607;
        end
        if (res < -8388608) begin
            res = -8388608;
        end

        beat.sample      = res[SAMPLE_W-1:0];
        beat.frame_index = frame_pos[FIDX_W-1:0];
        beat.last        = (frame_pos >= frame_len - 1);
        pending_samples.push_back(beat);
        results_predicted++;

        if (beat.last) begin
            frames_closed++;
            frame_pos   = 0;
            carrier_acc = '0;
            mod_acc     = '0;
            if (!reg_continuous) begin
                halted = 1'b1;
            end
        end else begin
            frame_pos   = frame_pos + 1;
            carrier_acc = carrier_acc + reg_carrier_step;
            mod_acc     = mod_acc + reg_mod_step;
        end
    endtask

    // ------------------------------------------------------------------
    // Output side: random stalls, hold-off, and the per-field check
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        sample_beat_t want;
        if (s_axis_tvalid && s_axis_tready === 1'b0) begin
            input_stalls++;
        end
        if (m_axis_tvalid === 1'b1 && m_axis_tready) begin
            if (pending_samples.size() == 0) begin
                $error("output beat with no sample expected: tdata %h tlast %b",
                       m_axis_tdata, m_axis_tlast);
                mismatch_count++;
            end else begin
                want = pending_samples.pop_front();
                results_checked++;
                if (m_axis_tdata[SAMPLE_W-1:0] !== want.sample) begin
                    $error("sample: expected %0d, got %0d", want.sample,
                           $signed(m_axis_tdata[SAMPLE_W-1:0]));
                    mismatch_count++;
                end
                if (m_axis_tdata[SAMPLE_W +: FIDX_W] !== want.frame_index) begin
                    $error("frame_index: expected %0d, got %0d", want.frame_index,
                           m_axis_tdata[SAMPLE_W +: FIDX_W]);
                    mismatch_count++;
                end
                if (m_axis_tlast !== want.last) begin
                    $error("last_in_frame: expected %b, got %b", want.last, m_axis_tlast);
                    mismatch_count++;
                end
            end
        end
        // hold the sink off completely while a hold-off runs
        if (rx_hold) begin
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Shared drivers
    // ------------------------------------------------------------------
    // Offer one beat, idling first at the current rate, and advance the
    // model on the edge that takes it. Valid stays high on return.
    task automatic send_beat(input bit restart);
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= S_TDATA_W'(restart);
        do @(posedge i_clk); while (s_axis_tready !== 1'b1);
        next_sample(restart);
    endtask

    // Drop valid, wait out every queued sample, then let the pipeline
    // flush any beats swallowed by a stopped generator.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_samples.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (PIPE_SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0]  value);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        apply_reg(idx, value);
        reg_writes++;
        i_cfg_wr_en <= 1'b0;
        @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Straight out of reset: default registers, free-running first frame
    task automatic test_power_on_defaults();
        repeat (4) send_beat(1'b0);
        send_beat(1'b1);
        wait_drained();
    endtask

    // One-sample frames, stop and resume, zero seed, extreme steps and gain,
    // and a frame shortened under a counter already past its new end
    task automatic test_frame_edges();
        write_reg(CFG_FRAME_LOG2, 32'd0);
        write_reg(CFG_CONTINUOUS, 32'd0);
        write_reg(CFG_CARRIER_STEP, 32'hFFFF_FFFF);
        write_reg(CFG_MOD_STEP, 32'd0);
        write_reg(CFG_NOISE_GAIN, 32'h0000_FFFF);
        write_reg(CFG_NOISE_SEED, 32'd0);
        send_beat(1'b1);
        send_beat(1'b0);              // stopped: swallowed
        send_beat(1'b0);
        send_beat(1'b1);              // resume
        wait_drained();

        write_reg(CFG_CONTINUOUS, 32'd1);
        write_reg(CFG_FRAME_LOG2, 32'd1);
        repeat (3) send_beat(1'b0);
        wait_drained();

        write_reg(CFG_FRAME_LOG2, 32'd4);
        send_beat(1'b1);
        repeat (5) send_beat(1'b0);
        wait_drained();
        // shrink to two samples with the counter at six
        write_reg(CFG_FRAME_LOG2, 32'd1);
        repeat (2) send_beat(1'b0);
        wait_drained();
    endtask

    // Width masking, frame length clamp and spare indexes
    task automatic test_register_handling();
        write_reg(CFG_NOISE_GAIN, 32'hABCD_1234);
        write_reg(CFG_FRAME_LOG2, 32'hFFFF_FFE2);
        write_reg(CFG_CONTINUOUS, 32'hFFFF_FFFE);
        write_reg(CFG_SPARE_LO, 32'hFFFF_FFFF);
        write_reg(CFG_SPARE_HI, 32'h0000_0001);
        write_reg(CFG_CARRIER_STEP, 32'd0);
        write_reg(CFG_MOD_STEP, 32'hFFFF_FFFF);
        write_reg(CFG_NOISE_SEED, 32'hFFFF_FFFF);
        send_beat(1'b1);
        repeat (3) send_beat(1'b0);   // four-sample frame, then stop
        wait_drained();

        write_reg(CFG_FRAME_LOG2, 32'd31);    // clamps to the longest frame
        write_reg(CFG_NOISE_GAIN, 32'd0);
        send_beat(1'b1);
        send_beat(1'b0);
        wait_drained();
    endtask

    // Hold the sink off long enough to fill the pipeline and stall the
    // input, then pause the source until everything has drained.
    task automatic test_back_pressure();
        send_idle_pct = 0;
        rx_stall_pct  = 0;
        write_reg(CFG_CONTINUOUS, 32'd1);
        write_reg(CFG_FRAME_LOG2, 32'd3);
        write_reg(CFG_NOISE_GAIN, 32'd4096);
        fork
            begin
                rx_hold <= 1'b1;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
                rx_hold <= 1'b0;
            end
            begin
                send_beat(1'b1);
                repeat (79) send_beat(1'b0);
            end
        join
        wait_drained();
        repeat (40) send_beat(1'b0);
        wait_drained();
    endtask

    task automatic randomise_registers();
        logic [31:0] junk;
        logic [31:0] value;
        logic [4:0]  lg;
        int          pick;

        pick = $urandom_range(7);
        value = (pick == 0) ? 32'd0 : (pick == 1) ? 32'hFFFF_FFFF :
                (pick == 2) ? 32'($urandom_range(1, 1 << 24)) : 32'($urandom);
        write_reg(CFG_CARRIER_STEP, value);

        pick = $urandom_range(7);
        value = (pick == 0) ? 32'd0 : (pick == 1) ? 32'hFFFF_FFFF :
                (pick == 2) ? 32'($urandom_range(1, 1 << 22)) : 32'($urandom);
        write_reg(CFG_MOD_STEP, value);

        junk = $urandom;
        pick = $urandom_range(7);
        value[15:0]  = (pick == 0) ? 16'd0 : (pick == 1) ? 16'hFFFF : 16'($urandom);
        value[31:16] = ($urandom_range(3) == 0) ? junk[31:16] : 16'd0;
        write_reg(CFG_NOISE_GAIN, value);

        // keep frames short most of the time so they close and stop
        pick = $urandom_range(31);
        lg   = (pick < 26) ? 5'($urandom_range(0, 5)) :
               (pick < 29) ? 5'd16 : 5'($urandom_range(17, 31));
        junk = $urandom;
        write_reg(CFG_FRAME_LOG2, {($urandom_range(3) == 0) ? junk[31:5] : 27'd0, lg});

        junk = $urandom;
        write_reg(CFG_CONTINUOUS, {($urandom_range(3) == 0) ? junk[31:1] : 31'd0,
                                   1'($urandom_range(1))});

        value = ($urandom_range(15) == 0) ? 32'd0 : 32'($urandom);
        write_reg(CFG_NOISE_SEED, value);

        if ($urandom_range(7) == 0) begin
            write_reg($urandom_range(1) ? CFG_SPARE_LO : CFG_SPARE_HI, 32'($urandom));
        end
    endtask

    // Randomised bursts under each idle profile; a stopped generator is
    // mostly restarted so that frames keep flowing
    task automatic test_random_traffic();
        int tx_pct [4] = '{0, 56, 0, 23};
        int rx_pct [4] = '{0, 0, 56, 23};
        int ph;
        int goal;
        int burst;
        for (ph = 0; ph < 4; ph++) begin
            wait_drained();
            send_idle_pct = tx_pct[ph];
            rx_stall_pct  = rx_pct[ph];
            goal = results_predicted + 370;
            while (results_predicted < goal) begin
                wait_drained();
                randomise_registers();
                burst = $urandom_range(20, 80);
                repeat (burst) begin
                    send_beat(halted ? ($urandom_range(9) < 8) : ($urandom_range(39) == 0));
                end
            end
        end
        wait_drained();
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        int i;
        for (i = 0; i < LUT_DEPTH; i++) begin
            sine_lut[i] = sine_q15(i);
        end
        reset_model();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_power_on_defaults();
        test_frame_edges();
        test_register_handling();
        test_back_pressure();
        test_random_traffic();
        wait_drained();

        if (pending_samples.size() != 0) begin
            $error("%0d expected samples never arrived", pending_samples.size());
            mismatch_count++;
        end
        $display("Checked %0d samples over %0d closed frames after %0d register writes,",
                 results_checked, frames_closed, reg_writes);
        $display("with %0d cycles of input stall under four idle profiles and a hold-off.",
                 input_stalls);
        if (mismatch_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

/* filelist.f */
design/amtsg_pkg.sv
design/am_test_signal_generator_top.sv
tb/am_test_signal_generator_top_tb.sv
